FILE: rtl/distance_field_next_step_assert.svh
// assertion macros for the checker file of the next-step block
// needs nothing else; each macro expands to one labelled concurrent assertion
`ifndef DISTANCE_FIELD_NEXT_STEP_ASSERT_SVH
`define DISTANCE_FIELD_NEXT_STEP_ASSERT_SVH

// same-cycle implication
`define DFNS_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("dfns: implication failed");

// next-cycle implication
`define DFNS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("dfns: next-cycle implication failed");

// a stalled request keeps valid and payload
`define DFNS_ASSERT_HOLD(lbl, ck, rn, vld, rdy, sig) \
  lbl: assert property (@(posedge ck) disable iff (!rn) \
    (vld && !rdy) |=> (vld && $stable(sig))) \
    else $error("dfns: stalled request changed");

`endif

FILE: rtl/dfns_pkg.sv
// types and constants of the distance field next-step block
// used by every module of the block; depends on nothing
package dfns_pkg;

  localparam int COORD_W = 6;
  localparam int DIST_W  = 13;
  localparam int CFG_W   = 7;
  // side lengths up to 511
  localparam int SIZE_W  = 9;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_TOWARD = 2'd1;
  localparam logic [1:0] OP_AWAY   = 2'd2;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // scan slot 0 is the start tile, slots 1..8 the neighbours
  localparam logic [3:0] SLOT_CENTRE = 4'd0;
  localparam logic [3:0] SLOT_LAST   = 4'd8;
  localparam logic [3:0] SLOT_DIAG0  = 4'd5;

  // neighbour order: E, W, S, N, SE, NE, SW, NW
  localparam logic signed [1:0] NBR_DX [8] =
    '{2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd1, -2'sd1, -2'sd1};
  localparam logic signed [1:0] NBR_DY [8] =
    '{2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1, -2'sd1};

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_TOWARD,
    CMD_AWAY,
    CMD_STAY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic [COORD_W-1:0]        x;
    logic [COORD_W-1:0]        y;
    logic [COORD_W-1:0]        tx;
    logic [COORD_W-1:0]        ty;
    logic                      blocked;
    logic signed [DIST_W-1:0]  distance;
    logic                      occupied;
  } cmd_t;

  // grid size in use, already capped at the storage side
  typedef struct packed {
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
  } geom_t;

endpackage

FILE: rtl/dfns_front.sv
// front end: size registers, request accept and classification into commands
// depends on dfns_pkg; feeds dfns_queue
module dfns_front #(
  parameter int MAX_SIDE = 64,
  parameter int DIST_MAX = 4095
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_op,
  input  logic [dfns_pkg::COORD_W-1:0]         in_tile_x,
  input  logic [dfns_pkg::COORD_W-1:0]         in_tile_y,
  input  logic [dfns_pkg::COORD_W-1:0]         in_target_x,
  input  logic [dfns_pkg::COORD_W-1:0]         in_target_y,
  input  logic                                 in_cell_blocked,
  input  logic signed [dfns_pkg::DIST_W-1:0]   in_cell_distance,
  input  logic                                 in_cell_occupied,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [dfns_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                 clearing,
  input  logic                                 push_ready,
  output logic                                 push_valid,
  output dfns_pkg::cmd_t                       push_data,
  output dfns_pkg::geom_t                      geom
);

  localparam logic [dfns_pkg::SIZE_W-1:0] SIDE = dfns_pkg::SIZE_W'(MAX_SIDE);
  localparam logic signed [17:0] DMAX = 18'(DIST_MAX);

  logic [dfns_pkg::CFG_W-1:0] grid_w_r, grid_w_nxt;
  logic [dfns_pkg::CFG_W-1:0] grid_h_r, grid_h_nxt;
  logic [dfns_pkg::SIZE_W-1:0] w_ext, h_ext, x_ext, y_ext;
  logic signed [17:0] d_ext;
  logic start_in, keep;

  always_comb begin
    grid_w_nxt = grid_w_r;
    grid_h_nxt = grid_h_r;
    if (cfg_we) begin
      unique case (cfg_index)
        dfns_pkg::REG_GRID_WIDTH:  grid_w_nxt = cfg_wdata;
        dfns_pkg::REG_GRID_HEIGHT: grid_h_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= dfns_pkg::CFG_W'(64);
      grid_h_r <= dfns_pkg::CFG_W'(64);
    end else begin
      grid_w_r <= grid_w_nxt;
      grid_h_r <= grid_h_nxt;
    end
  end

  assign w_ext  = {2'b00, grid_w_r};
  assign h_ext  = {2'b00, grid_h_r};
  assign geom.w = (w_ext > SIDE) ? SIDE : w_ext;
  assign geom.h = (h_ext > SIDE) ? SIDE : h_ext;

  assign x_ext    = {3'b000, in_tile_x};
  assign y_ext    = {3'b000, in_tile_y};
  assign start_in = (x_ext < geom.w) && (y_ext < geom.h);
  assign d_ext    = 18'(in_cell_distance);

  assign in_ready = push_ready && !clearing;

  always_comb begin
    push_data.kind     = dfns_pkg::CMD_STAY;
    push_data.x        = in_tile_x;
    push_data.y        = in_tile_y;
    push_data.tx       = in_target_x;
    push_data.ty       = in_target_y;
    push_data.blocked  = in_cell_blocked;
    push_data.distance = (d_ext > DMAX) ? dfns_pkg::DIST_W'(DIST_MAX) : in_cell_distance;
    push_data.occupied = in_cell_occupied;
    keep = 1'b0;
    unique case (in_op)
      dfns_pkg::OP_WRITE: begin
        // writes past the storage side are dropped
        push_data.kind = dfns_pkg::CMD_WRITE;
        keep = (x_ext < SIDE) && (y_ext < SIDE);
      end
      dfns_pkg::OP_TOWARD: begin
        push_data.kind = start_in ? dfns_pkg::CMD_TOWARD : dfns_pkg::CMD_STAY;
        keep = 1'b1;
      end
      dfns_pkg::OP_AWAY: begin
        push_data.kind = start_in ? dfns_pkg::CMD_AWAY : dfns_pkg::CMD_STAY;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push_valid = in_valid && in_ready && keep;

endmodule

FILE: rtl/dfns_queue.sv
// two-entry command queue between front and back end
// depends on dfns_pkg for the command type
module dfns_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  dfns_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output dfns_pkg::cmd_t pop_data
);

  localparam int QDEPTH = 2;
  localparam int PW     = $clog2(QDEPTH);

  dfns_pkg::cmd_t entry_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign push_ready = (cnt_r != (PW+1)'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule

FILE: rtl/dfns_back.sv
// back end: cell memories, occupancy clear after reset, neighbour scan sequencer
// and result register; depends on dfns_pkg, fed by dfns_queue
module dfns_back #(
  parameter int MAX_SIDE = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dfns_pkg::geom_t               geom,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  dfns_pkg::cmd_t                pop_data,
  output logic                          clearing,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dfns_pkg::COORD_W-1:0]  out_next_x,
  output logic [dfns_pkg::COORD_W-1:0]  out_next_y
);

  localparam int XW    = $clog2(MAX_SIDE);
  localparam int AW    = 2 * XW;
  localparam int DEPTH = 1 << AW;
  localparam int DW    = dfns_pkg::DIST_W;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  // control
  state_t         state_r, state_nxt;
  logic [AW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic           issuing_r, issuing_nxt;
  logic           eval_vld_r, eval_vld_nxt;
  logic           out_valid_r, out_valid_nxt;
  // payload
  dfns_pkg::cmd_t cur_r, cur_nxt;
  logic [3:0]     issue_idx_r, issue_idx_nxt;
  logic [3:0]     eval_idx_r, eval_idx_nxt;
  logic           eval_ing_r, eval_ing_nxt;
  logic signed [9:0] eval_nx_r, eval_nx_nxt, eval_ny_r, eval_ny_nxt;
  logic signed [DW-1:0] best_r, best_nxt;
  logic           alive_r, alive_nxt;
  logic [3:0]     orth_wall_r, orth_wall_nxt;
  logic [dfns_pkg::COORD_W-1:0] bx_r, bx_nxt, by_r, by_nxt;
  logic [dfns_pkg::COORD_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;

  // memories
  logic [DW:0]    wd_mem [DEPTH];
  logic           occ_mem [DEPTH];
  logic [DW:0]    rd_wd_r;
  logic           rd_occ_r;
  logic           wd_we, occ_we, occ_wdata;
  logic [AW-1:0]  wr_addr, occ_waddr, rd_addr;
  logic [8:0]     wx9, wy9;

  // scan address generation
  logic [2:0]        issue_k, eval_k;
  logic signed [1:0] dx, dy;
  logic signed [9:0] nx, ny;
  logic              in_grid;

  // neighbour evaluation
  logic              e_wall, e_occ, diag, corner, toward, better, is_target, take;
  logic signed [DW-1:0] e_dist;

  assign issue_k = issue_idx_r[2:0] - 3'd1;
  assign dx = (issue_idx_r == dfns_pkg::SLOT_CENTRE) ? 2'sd0 : dfns_pkg::NBR_DX[issue_k];
  assign dy = (issue_idx_r == dfns_pkg::SLOT_CENTRE) ? 2'sd0 : dfns_pkg::NBR_DY[issue_k];
  assign nx = $signed({4'b0000, cur_r.x}) + 10'(dx);
  assign ny = $signed({4'b0000, cur_r.y}) + 10'(dy);
  assign in_grid = !nx[9] && !ny[9] && (nx < $signed({1'b0, geom.w}))
                && (ny < $signed({1'b0, geom.h}));
  assign rd_addr = {ny[XW-1:0], nx[XW-1:0]};

  assign wx9     = {3'b000, pop_data.x};
  assign wy9     = {3'b000, pop_data.y};
  assign wr_addr = {wy9[XW-1:0], wx9[XW-1:0]};

  always_ff @(posedge clk) begin
    if (wd_we) wd_mem[wr_addr] <= {pop_data.blocked, pop_data.distance};
    rd_wd_r <= wd_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (occ_we) occ_mem[occ_waddr] <= occ_wdata;
    rd_occ_r <= occ_mem[rd_addr];
  end

  assign e_wall    = rd_wd_r[DW];
  assign e_dist    = $signed(rd_wd_r[DW-1:0]);
  assign e_occ     = rd_occ_r;
  assign eval_k    = eval_idx_r[2:0] - 3'd1;
  assign diag      = (eval_idx_r >= dfns_pkg::SLOT_DIAG0);
  assign toward    = (cur_r.kind == dfns_pkg::CMD_TOWARD);
  assign better    = toward ? (e_dist < best_r) : (e_dist > best_r);
  assign is_target = (eval_nx_r == $signed({4'b0000, cur_r.tx}))
                  && (eval_ny_r == $signed({4'b0000, cur_r.ty}));

  // orthogonal wall bits: E, W, S, N; a diagonal may not cut a walled corner
  always_comb begin
    case (eval_k)
      3'd4:    corner = orth_wall_r[0] | orth_wall_r[2];
      3'd5:    corner = orth_wall_r[0] | orth_wall_r[3];
      3'd6:    corner = orth_wall_r[1] | orth_wall_r[2];
      3'd7:    corner = orth_wall_r[1] | orth_wall_r[3];
      default: corner = 1'b0;
    endcase
  end

  assign take = alive_r && eval_ing_r && !e_wall && !(diag && corner) && !e_dist[DW-1]
             && better && (!e_occ || (toward && is_target));

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    issuing_nxt   = issuing_r;
    eval_vld_nxt  = 1'b0;
    out_valid_nxt = out_valid_r;
    cur_nxt       = cur_r;
    issue_idx_nxt = issue_idx_r;
    eval_idx_nxt  = eval_idx_r;
    eval_ing_nxt  = eval_ing_r;
    eval_nx_nxt   = eval_nx_r;
    eval_ny_nxt   = eval_ny_r;
    best_nxt      = best_r;
    alive_nxt     = alive_r;
    orth_wall_nxt = orth_wall_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    pop_ready     = 1'b0;
    wd_we         = 1'b0;
    occ_we        = 1'b0;
    occ_waddr     = wr_addr;
    occ_wdata     = pop_data.occupied;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        occ_we      = 1'b1;
        occ_waddr   = clr_cnt_r;
        occ_wdata   = 1'b0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          cur_nxt = pop_data;
          bx_nxt  = pop_data.x;
          by_nxt  = pop_data.y;
          unique case (pop_data.kind)
            dfns_pkg::CMD_WRITE: begin
              wd_we  = 1'b1;
              occ_we = 1'b1;
            end
            dfns_pkg::CMD_STAY: state_nxt = ST_EMIT;
            default: begin
              issue_idx_nxt = dfns_pkg::SLOT_CENTRE;
              issuing_nxt   = 1'b1;
              state_nxt     = ST_SCAN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (issuing_r) begin
          eval_vld_nxt  = 1'b1;
          eval_idx_nxt  = issue_idx_r;
          eval_ing_nxt  = in_grid;
          eval_nx_nxt   = nx;
          eval_ny_nxt   = ny;
          issue_idx_nxt = issue_idx_r + 4'd1;
          if (issue_idx_r == dfns_pkg::SLOT_LAST) issuing_nxt = 1'b0;
        end
        if (eval_vld_r) begin
          if (eval_idx_r == dfns_pkg::SLOT_CENTRE) begin
            // unreachable start tile stays put
            best_nxt  = e_dist;
            alive_nxt = !e_dist[DW-1];
          end else begin
            if (!diag) orth_wall_nxt[eval_k[1:0]] = e_wall;
            if (take) begin
              best_nxt = e_dist;
              bx_nxt   = eval_nx_r[dfns_pkg::COORD_W-1:0];
              by_nxt   = eval_ny_r[dfns_pkg::COORD_W-1:0];
            end
          end
          if (eval_idx_r == dfns_pkg::SLOT_LAST) state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = bx_r;
          out_y_nxt     = by_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      issuing_r   <= 1'b0;
      eval_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      issuing_r   <= issuing_nxt;
      eval_vld_r  <= eval_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    issue_idx_r <= issue_idx_nxt;
    eval_idx_r  <= eval_idx_nxt;
    eval_ing_r  <= eval_ing_nxt;
    eval_nx_r   <= eval_nx_nxt;
    eval_ny_r   <= eval_ny_nxt;
    best_r      <= best_nxt;
    alive_r     <= alive_nxt;
    orth_wall_r <= orth_wall_nxt;
    bx_r        <= bx_nxt;
    by_r        <= by_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
  end

  assign clearing   = (state_r == ST_CLEAR);
  assign out_valid  = out_valid_r;
  assign out_next_x = out_x_r;
  assign out_next_y = out_y_r;

endmodule

FILE: rtl/distance_field_next_step.sv
// top level of the distance field next-step block: front, queue and back end
// depends on dfns_pkg, dfns_front, dfns_queue and dfns_back
//
//   channel   handshake            carries
//   in_*      in_valid/in_ready    op, tile, target, cell contents
//   out_*     out_valid/out_ready  next tile
//   cfg_*     cfg_we               grid width/height by index
//
// a write request is written to the cell memories as it is popped; a step query pops,
// issues nine memory reads through the single read port, evaluates each from the
// registered read data and loads the result register. op 3 and writes past the
// storage side are dropped. after reset the occupancy memory is cleared one cell a
// cycle with in_ready low; size writes still land.
// a two-entry queue lets the front keep accepting while a result waits.
module distance_field_next_step #(
  parameter int MAX_SIDE = 64,
  parameter int DIST_MAX = 4095
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_op,
  input  logic [dfns_pkg::COORD_W-1:0]         in_tile_x,
  input  logic [dfns_pkg::COORD_W-1:0]         in_tile_y,
  input  logic [dfns_pkg::COORD_W-1:0]         in_target_x,
  input  logic [dfns_pkg::COORD_W-1:0]         in_target_y,
  input  logic                                 in_cell_blocked,
  input  logic signed [dfns_pkg::DIST_W-1:0]   in_cell_distance,
  input  logic                                 in_cell_occupied,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [dfns_pkg::COORD_W-1:0]         out_next_x,
  output logic [dfns_pkg::COORD_W-1:0]         out_next_y,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [dfns_pkg::CFG_W-1:0]           cfg_wdata
);

  logic            clearing;
  logic            push_valid, push_ready, pop_valid, pop_ready;
  dfns_pkg::cmd_t  push_data, pop_data;
  dfns_pkg::geom_t geom;

  dfns_front #(
    .MAX_SIDE (MAX_SIDE),
    .DIST_MAX (DIST_MAX)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_tile_x        (in_tile_x),
    .in_tile_y        (in_tile_y),
    .in_target_x      (in_target_x),
    .in_target_y      (in_target_y),
    .in_cell_blocked  (in_cell_blocked),
    .in_cell_distance (in_cell_distance),
    .in_cell_occupied (in_cell_occupied),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .clearing         (clearing),
    .push_ready       (push_ready),
    .push_valid       (push_valid),
    .push_data        (push_data),
    .geom             (geom)
  );

  dfns_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  dfns_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .geom       (geom),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .clearing   (clearing),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_next_x (out_next_x),
    .out_next_y (out_next_y)
  );

endmodule

FILE: rtl/dfns_checker.sv
// port-level checks of the next-step block and the bind that attaches them
// depends on distance_field_next_step_assert.svh and the top level's ports
`include "distance_field_next_step_assert.svh"

module dfns_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_next_x,
  input logic [5:0] out_next_y
);

  // occupancy clear runs straight after reset: nothing taken, nothing shown
  `DFNS_ASSERT_IMPL(a_rst_quiet, clk, rst_n, $past(!rst_n), !in_ready && !out_valid)
  `DFNS_ASSERT_NEXT(a_clear_busy, clk, rst_n, $past(!rst_n), !in_ready && !out_valid)
  `DFNS_ASSERT_HOLD(a_out_hold, clk, rst_n, out_valid, out_ready, {out_next_x, out_next_y})

endmodule

bind distance_field_next_step dfns_checker u_dfns_checker (.*);

FILE: tb/sv/distance_field_next_step_checker.sv
// checker of the distance field next-step block: keeps its own copy of the cell stores,
// works out the next tile for every step request and compares it with the block's result
// depends on dfns_pkg
module distance_field_next_step_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [1:0]                         in_op,
  input  logic [dfns_pkg::COORD_W-1:0]       in_tile_x,
  input  logic [dfns_pkg::COORD_W-1:0]       in_tile_y,
  input  logic [dfns_pkg::COORD_W-1:0]       in_target_x,
  input  logic [dfns_pkg::COORD_W-1:0]       in_target_y,
  input  logic                               in_cell_blocked,
  input  logic signed [dfns_pkg::DIST_W-1:0] in_cell_distance,
  input  logic                               in_cell_occupied,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [dfns_pkg::COORD_W-1:0]       out_next_x,
  input  logic [dfns_pkg::COORD_W-1:0]       out_next_y,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [dfns_pkg::CFG_W-1:0]         cfg_wdata,
  output int                                 mismatches,
  output int                                 steps_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE       = 64;
  localparam int DIST_LIMIT = 4095;

  // E, W, S, N, SE, NE, SW, NW
  localparam int STEP_DX [8] = '{1, -1, 0, 0, 1, 1, -1, -1};
  localparam int STEP_DY [8] = '{0, 0, 1, -1, 1, -1, 1, -1};

  typedef struct packed {
    logic [dfns_pkg::COORD_W-1:0] x;
    logic [dfns_pkg::COORD_W-1:0] y;
  } tile_t;

  logic                               wall_q [SIDE*SIDE];
  logic signed [dfns_pkg::DIST_W-1:0] dist_q [SIDE*SIDE];
  logic                               occ_q  [SIDE*SIDE];
  int                                 cols;
  int                                 rows;
  tile_t                              next_tiles_due [$];

  function automatic int slot_of(input int x, input int y);
    return y * SIDE + x;
  endfunction

  // size registers are capped at the storage side
  function automatic bit on_grid(input int x, input int y);
    return x >= 0 && y >= 0 && x < (cols > SIDE ? SIDE : cols) &&
           y < (rows > SIDE ? SIDE : rows);
  endfunction

  function automatic tile_t pick_next_tile(input logic [1:0] op, input int cx, input int cy,
                                           input int tx, input int ty);
    tile_t best_tile;
    int    best;
    int    nx;
    int    ny;
    int    nd;
    bit    toward;
    best_tile.x = dfns_pkg::COORD_W'(cx);
    best_tile.y = dfns_pkg::COORD_W'(cy);
    if (!on_grid(cx, cy)) return best_tile;
    best = int'(dist_q[slot_of(cx, cy)]);
    if (best < 0) return best_tile;
    toward = (op == dfns_pkg::OP_TOWARD);
    for (int k = 0; k < 8; k++) begin
      nx = cx + STEP_DX[k];
      ny = cy + STEP_DY[k];
      if (!on_grid(nx, ny)) continue;
      if (wall_q[slot_of(nx, ny)]) continue;
      // a diagonal may not cut past a wall on either corner
      if (STEP_DX[k] != 0 && STEP_DY[k] != 0 &&
          (wall_q[slot_of(nx, cy)] || wall_q[slot_of(cx, ny)])) continue;
      nd = int'(dist_q[slot_of(nx, ny)]);
      if (nd < 0) continue;
      if (toward ? (nd >= best) : (nd <= best)) continue;
      // the target may be entered even when occupied, but only when heading for it
      if (occ_q[slot_of(nx, ny)] && !(toward && nx == tx && ny == ty)) continue;
      best = nd;
      best_tile.x = dfns_pkg::COORD_W'(nx);
      best_tile.y = dfns_pkg::COORD_W'(ny);
    end
    return best_tile;
  endfunction

  always @(posedge clk) begin
    tile_t due;
    int    d;
    if (!rst_n) begin
      foreach (occ_q[i]) occ_q[i] = 1'b0;
      cols = SIDE;
      rows = SIDE;
      next_tiles_due.delete();
      mismatches = 0;
    end else begin
      // results first, so a request taken in the same cycle cannot cover a stray one
      if (out_valid && out_ready) begin
        if (next_tiles_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: next tile (%0d,%0d) with no step request waiting", $time,
                     out_next_x, out_next_y);
        end else begin
          due = next_tiles_due.pop_front();
          if (out_next_x !== due.x || out_next_y !== due.y) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: next tile x %0d y %0d, expected x %0d y %0d", $time,
                       out_next_x, out_next_y, due.x, due.y);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == dfns_pkg::REG_GRID_WIDTH) cols = int'(cfg_wdata);
        else rows = int'(cfg_wdata);
      end
      if (in_valid && in_ready) begin
        case (in_op) inside
          dfns_pkg::OP_WRITE: begin
            d = int'(in_cell_distance);
            if (d > DIST_LIMIT) d = DIST_LIMIT;
            if (int'(in_tile_x) < SIDE && int'(in_tile_y) < SIDE) begin
              wall_q[slot_of(int'(in_tile_x), int'(in_tile_y))] = in_cell_blocked;
              dist_q[slot_of(int'(in_tile_x), int'(in_tile_y))] = dfns_pkg::DIST_W'(d);
              occ_q[slot_of(int'(in_tile_x), int'(in_tile_y))]  = in_cell_occupied;
            end
          end
          dfns_pkg::OP_TOWARD, dfns_pkg::OP_AWAY:
            next_tiles_due.push_back(pick_next_tile(in_op, int'(in_tile_x), int'(in_tile_y),
                                                    int'(in_target_x), int'(in_target_y)));
          default: ;
        endcase
      end
    end
    steps_pending = next_tiles_due.size();
  end

endmodule

FILE: tb/sv/distance_field_next_step_tb.sv
// testbench top of the distance field next-step block: clock, reset, request stimulus,
// result back-pressure and the verdict
// depends on dfns_pkg, the block's RTL and distance_field_next_step_checker
module distance_field_next_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_SPARE   = 2'd3;
  localparam int         SIDE       = 64;
  localparam int         DIST_TOP   = 4095;
  localparam int         IDLE_LIMIT = 20000;

  typedef enum {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_RHYTHM} sink_mode_t;

  logic                               clk              = 1'b0;
  logic                               rst_n            = 1'b0;
  logic                               in_valid         = 1'b0;
  logic                               in_ready;
  logic [1:0]                         in_op            = dfns_pkg::OP_WRITE;
  logic [dfns_pkg::COORD_W-1:0]       in_tile_x        = '0;
  logic [dfns_pkg::COORD_W-1:0]       in_tile_y        = '0;
  logic [dfns_pkg::COORD_W-1:0]       in_target_x      = '0;
  logic [dfns_pkg::COORD_W-1:0]       in_target_y      = '0;
  logic                               in_cell_blocked  = 1'b0;
  logic signed [dfns_pkg::DIST_W-1:0] in_cell_distance = '0;
  logic                               in_cell_occupied = 1'b0;
  logic                               out_valid;
  logic                               out_ready        = 1'b0;
  logic [dfns_pkg::COORD_W-1:0]       out_next_x;
  logic [dfns_pkg::COORD_W-1:0]       out_next_y;
  logic                               cfg_we           = 1'b0;
  logic                               cfg_index        = dfns_pkg::REG_GRID_WIDTH;
  logic [dfns_pkg::CFG_W-1:0]         cfg_wdata        = '0;
  logic                               hold_go          = 1'b0;

  int mismatches;
  int steps_pending;
  int sent        = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  int cols_live   = SIDE;
  int rows_live   = SIDE;
  bit loaded [SIDE][SIDE];

  always #4 clk = ~clk;

  distance_field_next_step dut (.*);

  distance_field_next_step_checker next_step_check (.*);

  // one request; valid stays up between back-to-back requests of a burst
  task automatic offer(input logic [1:0] op, input int x, input int y, input int tx,
                       input int ty, input int blk, input int distance, input int occ);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    in_op            <= op;
    in_tile_x        <= dfns_pkg::COORD_W'(x);
    in_tile_y        <= dfns_pkg::COORD_W'(y);
    in_target_x      <= dfns_pkg::COORD_W'(tx);
    in_target_y      <= dfns_pkg::COORD_W'(ty);
    in_cell_blocked  <= 1'(blk);
    in_cell_distance <= dfns_pkg::DIST_W'(distance);
    in_cell_occupied <= 1'(occ);
    in_valid         <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (op != OP_SPARE) sent++;
  endtask

  task automatic put_cell(input int x, input int y, input int blk, input int distance,
                          input int occ);
    offer(dfns_pkg::OP_WRITE, x, y, $urandom_range(0, 63), $urandom_range(0, 63), blk,
          distance, occ);
    loaded[y][x] = 1'b1;
  endtask

  // distances mostly small so that neighbours compete, with the extremes mixed in
  task automatic write_cell(input int x, input int y);
    int r;
    int distance;
    r = $urandom_range(0, 99);
    if (r < 65)      distance = $urandom_range(0, 12);
    else if (r < 73) distance = -1;
    else if (r < 78) distance = -int'($urandom_range(1, 4096));
    else if (r < 84) distance = DIST_TOP - int'($urandom_range(0, 3));
    else             distance = int'($urandom_range(0, 8191)) - 4096;
    put_cell(x, y, ($urandom_range(0, 99) < 15) ? 1 : 0, distance,
             ($urandom_range(0, 99) < 20) ? 1 : 0);
  endtask

  // every in-grid cell a step request may look at has to hold data first
  task automatic load_around(input int cx, input int cy);
    int nx;
    int ny;
    for (int dy = -1; dy <= 1; dy++)
      for (int dx = -1; dx <= 1; dx++) begin
        nx = cx + dx;
        ny = cy + dy;
        if (nx >= 0 && ny >= 0 && nx < cols_live && ny < rows_live && !loaded[ny][nx])
          write_cell(nx, ny);
      end
  endtask

  task automatic step_from(input int x, input int y);
    int r;
    int tx;
    int ty;
    r  = $urandom_range(0, 99);
    tx = $urandom_range(0, 63);
    ty = $urandom_range(0, 63);
    // a neighbouring target makes the occupancy exemption bite
    if (r < 50) begin
      tx = (x + int'($urandom_range(0, 2)) - 1) & 63;
      ty = (y + int'($urandom_range(0, 2)) - 1) & 63;
    end else if (r < 60) begin
      tx = x;
      ty = y;
    end
    load_around(x, y);
    offer($urandom_range(0, 1) ? dfns_pkg::OP_TOWARD : dfns_pkg::OP_AWAY, x, y, tx, ty,
          $urandom_range(0, 1), int'($urandom_range(0, 8191)), $urandom_range(0, 1));
  endtask

  function automatic int pick_coord(input int lim);
    int r;
    r = $urandom_range(0, 99);
    if (lim == 0 || r < 20) return $urandom_range(0, 63);
    if (r < 28) return 0;
    if (r < 35) return lim - 1;
    return $urandom_range(0, lim - 1);
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (steps_pending != 0);
  endtask

  // resize the grid while idle, then run random requests
  task automatic run_phase(input int w, input int h, input int n, input bit with_hold);
    int goal;
    int r;
    int x;
    int y;
    wait_drained();
    // a write may still sit in the block after the last result
    repeat (30) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= dfns_pkg::REG_GRID_WIDTH;
    cfg_wdata <= dfns_pkg::CFG_W'(w);
    @(negedge clk);
    cfg_index <= dfns_pkg::REG_GRID_HEIGHT;
    cfg_wdata <= dfns_pkg::CFG_W'(h);
    @(negedge clk);
    cfg_we    <= 1'b0;
    cols_live = (w > SIDE) ? SIDE : w;
    rows_live = (h > SIDE) ? SIDE : h;
    goal = sent + n;
    while (sent < goal) begin
      if (with_hold && !hold_go && goal - sent < n / 2) hold_go <= 1'b1;
      x = pick_coord(cols_live);
      y = pick_coord(rows_live);
      r = $urandom_range(0, 99);
      if (r < 45) begin
        repeat ($urandom_range(1, 6))
          write_cell((x + int'($urandom_range(0, 2)) - 1) & 63,
                     (y + int'($urandom_range(0, 2)) - 1) & 63);
        step_from(x, y);
      end else if (r < 75) begin
        step_from(x, y);
      end else if (r < 94) begin
        write_cell($urandom_range(0, 63), $urandom_range(0, 63));
      end else begin
        offer(OP_SPARE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
              $urandom_range(0, 63), $urandom_range(0, 1), int'($urandom_range(0, 8191)),
              $urandom_range(0, 1));
      end
    end
  endtask

  initial begin : result_sink
    sink_mode_t mode;
    int         tick;
    bit         held;
    tick = 0;
    held = 1'b0;
    forever begin
      mode = sink_mode_t'($urandom_range(0, 3));
      repeat ($urandom_range(10, 80)) begin
        @(negedge clk);
        tick++;
        if (hold_go && !held) begin
          // long hold-off: the queue fills and the input backs up
          out_ready <= 1'b0;
          repeat (400) @(negedge clk);
          held = 1'b1;
        end
        case (mode)
          SINK_OPEN:   out_ready <= 1'b1;
          SINK_COIN:   out_ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:     out_ready <= (tick % 3 != 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // hand-built neighbourhood around (10,10)
    put_cell(10, 10, 0, 5, 0);
    put_cell(11, 10, 0, 4, 0);
    put_cell(9, 10, 0, 6, 0);
    put_cell(10, 11, 0, 3, 1);
    put_cell(10, 9, 0, 7, 0);
    put_cell(11, 11, 0, 3, 0);
    put_cell(11, 9, 0, 8, 0);
    put_cell(9, 11, 0, -1, 0);
    put_cell(9, 9, 0, DIST_TOP, 1);
    offer(dfns_pkg::OP_TOWARD, 10, 10, 0, 0, 0, 0, 0);
    // occupied south neighbour is the target
    offer(dfns_pkg::OP_TOWARD, 10, 10, 10, 11, 0, 0, 0);
    offer(dfns_pkg::OP_AWAY, 10, 10, 0, 0, 0, 0, 0);
    offer(dfns_pkg::OP_AWAY, 10, 10, 9, 9, 0, 0, 0);
    // wall to the east: the south-east diagonal cuts its corner
    put_cell(11, 10, 1, 0, 0);
    offer(dfns_pkg::OP_TOWARD, 10, 10, 0, 0, 0, 0, 0);
    // start tile unreachable
    put_cell(10, 10, 0, -4096, 0);
    offer(dfns_pkg::OP_TOWARD, 10, 10, 0, 0, 0, 0, 0);
    offer(OP_SPARE, 63, 63, 63, 63, 1, -1, 1);
    // grid corners
    put_cell(63, 63, 0, 0, 1);
    load_around(63, 63);
    offer(dfns_pkg::OP_AWAY, 63, 63, 63, 63, 1, DIST_TOP, 1);
    load_around(0, 0);
    offer(dfns_pkg::OP_TOWARD, 0, 0, 1, 1, 0, 0, 0);

    run_phase(8, 8, 300, 1'b0);
    run_phase(1, 1, 60, 1'b0);
    run_phase(64, 64, 400, 1'b0);
    run_phase(0, 9, 40, 1'b0);
    run_phase(100, 2, 150, 1'b0);
    run_phase(3, 127, 150, 1'b0);
    run_phase(16, 12, 500, 1'b1);

    wait_drained();
    repeat (50) @(negedge clk);
    if (mismatches == 0 && steps_pending == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/dfns_pkg.sv
rtl/dfns_front.sv
rtl/dfns_queue.sv
rtl/dfns_back.sv
rtl/distance_field_next_step.sv
rtl/dfns_checker.sv
tb/sv/distance_field_next_step_checker.sv
tb/sv/distance_field_next_step_tb.sv
